>>> rtl/ntz_pkg.sv
// Shared widths, types and division constants for the NZ local time converter.
// No dependencies; every other file in rtl imports this package.
package ntz_pkg;

  localparam int EPOCH_W = 38;
  localparam int DAYS_W  = 22;
  localparam int SOD_W   = 17;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int DOY_W   = 9;
  localparam int WDAY_W  = 3;

  // Depth of the days-to-civil pipeline.
  localparam int CIV_LAT = 7;

  localparam logic [SOD_W-1:0]  SECS_PER_DAY   = 17'd86400;
  localparam logic [SOD_W-1:0]  STD_OFFSET     = 17'd43200;
  localparam logic [SOD_W-1:0]  DST_OFFSET     = 17'd46800;
  // 02:00 at +12 h and 03:00 at +13 h both fall at 14:00 UTC the day before.
  localparam logic [SOD_W-1:0]  SWITCH_SOD     = 17'd50400;
  localparam logic [DAYS_W-1:0] DAY_SHIFT      = 22'd719468;
  localparam logic [17:0]       ERA_DAYS       = 18'd146097;

  // Reciprocals: floor(x / c) == (x * M) >> S for every x of the stated width.
  localparam int SH_675  = 41;
  localparam logic [31:0] M_675  = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
  localparam int SH_7W   = 25;
  localparam logic [22:0] M_7W   = 23'(((64'd1 << 25) + 64'd6) / 64'd7);
  localparam int SH_ERA  = 40;
  localparam logic [22:0] M_ERA  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam int SH_1460 = 29;
  localparam logic [18:0] M_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam int SH_365  = 27;
  localparam logic [18:0] M_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam int SH_100  = 16;
  localparam logic [9:0]  M_100  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam int SH_153  = 19;
  localparam logic [11:0] M_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam int SH_5    = 14;
  localparam logic [11:0] M_5    = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
  localparam int SH_3600 = 29;
  localparam logic [17:0] M_3600 = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam int SH_60   = 18;
  localparam logic [12:0] M_60   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam int SH_7S   = 13;
  localparam logic [10:0] M_7S   = 11'(((64'd1 << 13) + 64'd6) / 64'd7);

  localparam int CIV_SIDE_W = 42;
  typedef logic [CIV_SIDE_W-1:0] civ_side_t;

  // UTC day number, second of day and weekday (0 is Sunday).
  typedef struct packed {
    logic [DAYS_W-1:0] z;
    logic [SOD_W-1:0]  sod;
    logic [WDAY_W-1:0] wday;
  } utc_side_t;

  // Civil date plus the March-based day of year, month index and leap flag.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DOY_W-1:0]   doy;
    logic [3:0]         mp;
    logic               leap;
  } civ_date_t;

endpackage

>>> rtl/ntz_split.sv
// Splits an epoch into UTC day number, second of day and weekday (4 stages).
// Depends on ntz_pkg.
module ntz_split (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         valid_i,
  input  logic [ntz_pkg::EPOCH_W-1:0]  epoch_i,
  output logic                         valid_o,
  output ntz_pkg::utc_side_t           side_o
);
  import ntz_pkg::*;

  logic [3:0]        v_r;
  logic [21:0]       q1_r;
  logic [30:0]       n1_r;
  logic [6:0]        lo1_r;
  logic [62:0]       prod1;
  logic [DAYS_W-1:0] z2_r;
  logic [SOD_W-1:0]  sod2_r;
  logic [30:0]       rem_full;
  logic [44:0]       prod3;
  logic [19:0]       wq3_r;
  logic [DAYS_W-1:0] z3_r;
  logic [SOD_W-1:0]  sod3_r;
  logic [DAYS_W-1:0] x3;
  logic [DAYS_W-1:0] wrem;
  utc_side_t         side_r;

  // 86400 = 128 * 675: the low seven bits go straight into the second of day.
  assign prod1    = 63'(epoch_i[EPOCH_W-1:7]) * 63'(M_675);
  assign rem_full = n1_r - 31'(q1_r) * 31'd675;
  assign prod3    = 45'(z2_r + 22'd4) * 45'(M_7W);
  assign x3       = z3_r + 22'd4;
  assign wrem     = x3 - 22'(wq3_r) * 22'd7;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r   <= prod1[62:SH_675];
      n1_r   <= epoch_i[EPOCH_W-1:7];
      lo1_r  <= epoch_i[6:0];
      z2_r   <= q1_r;
      sod2_r <= {rem_full[9:0], lo1_r};
      wq3_r  <= prod3[44:SH_7W];
      z3_r   <= z2_r;
      sod3_r <= sod2_r;
      side_r.z    <= z3_r;
      side_r.sod  <= sod3_r;
      side_r.wday <= wrem[WDAY_W-1:0];
    end
  end

  assign valid_o = v_r[3];
  assign side_o  = side_r;

endmodule

>>> rtl/ntz_civil.sv
// Days-to-civil date conversion in seven stages, with a side word carried along.
// Depends on ntz_pkg.
module ntz_civil (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  logic [ntz_pkg::DAYS_W-1:0]  z_i,
  input  ntz_pkg::civ_side_t          side_i,
  output logic                        valid_o,
  output ntz_pkg::civ_date_t          date_o,
  output ntz_pkg::civ_side_t          side_o
);
  import ntz_pkg::*;

  logic [CIV_LAT-1:0] v_r;
  civ_side_t          side_r [CIV_LAT];

  logic [DAYS_W-1:0] zz;
  logic [44:0]       p_era;
  logic [DAYS_W-1:0] zz1_r;
  logic [4:0]        era1_r;
  logic [DAYS_W-1:0] doe_full;
  logic [17:0]       doe2_r;
  logic [4:0]        era2_r;
  logic [36:0]       p1460;
  logic [2:0]        c36524;
  logic              c146096;
  logic [17:0]       t3;
  logic [17:0]       t3_r;
  logic [17:0]       doe3_r;
  logic [4:0]        era3_r;
  logic [36:0]       p365;
  logic [8:0]        yoe4_r;
  logic [17:0]       doe4_r;
  logic [4:0]        era4_r;
  logic [18:0]       p100;
  logic [17:0]       base5;
  logic [17:0]       doy_full;
  logic [DOY_W-1:0]  doy5_r;
  logic [8:0]        yoe5_r;
  logic [4:0]        era5_r;
  logic [10:0]       x6;
  logic [22:0]       p153;
  logic [3:0]        mp6_r;
  logic [DOY_W-1:0]  doy6_r;
  logic [8:0]        yoe6_r;
  logic [4:0]        era6_r;
  logic [10:0]       x7;
  logic [22:0]       p5;
  logic [DOY_W-1:0]  day_full;
  logic              jan_feb;
  logic [9:0]        yr400;
  civ_date_t         date7;
  civ_date_t         date_r;

  always_comb begin
    zz       = z_i + DAY_SHIFT;
    p_era    = 45'(zz) * 45'(M_ERA);
    doe_full = zz1_r - 22'(era1_r) * 22'(ERA_DAYS);

    p1460   = 37'(doe2_r) * 37'(M_1460);
    c36524  = 3'(doe2_r >= 18'd36524) + 3'(doe2_r >= 18'd73048)
            + 3'(doe2_r >= 18'd109572) + 3'(doe2_r >= 18'd146096);
    c146096 = (doe2_r == 18'd146096);
    t3      = doe2_r - 18'(p1460[36:SH_1460]) + 18'(c36524) - 18'(c146096);

    p365 = 37'(t3_r) * 37'(M_365);

    p100     = 19'(yoe4_r) * 19'(M_100);
    base5    = 18'(yoe4_r) * 18'd365 + 18'(yoe4_r[8:2]) - 18'(p100[18:SH_100]);
    doy_full = doe4_r - base5;

    x6   = 11'(doy5_r) * 11'd5 + 11'd2;
    p153 = 23'(x6) * 23'(M_153);

    x7       = 11'(mp6_r) * 11'd153 + 11'd2;
    p5       = 23'(x7) * 23'(M_5);
    day_full = doy6_r - p5[22:SH_5] + 9'd1;
    jan_feb  = (mp6_r >= 4'd10);
    // Year modulo 400 decides the leap rule; 400 itself counts as zero.
    yr400    = 10'(yoe6_r) + 10'(jan_feb);

    date7.year  = 14'(yoe6_r) + 14'(era6_r) * 14'd400 + 14'(jan_feb);
    date7.month = jan_feb ? (mp6_r - 4'd9) : (mp6_r + 4'd3);
    date7.day   = day_full[DAY_W-1:0];
    date7.doy   = doy6_r;
    date7.mp    = mp6_r;
    date7.leap  = (yr400[1:0] == 2'd0) && (yr400 != 10'd100) && (yr400 != 10'd200)
                  && (yr400 != 10'd300);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[CIV_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 1; k < CIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
      zz1_r  <= zz;
      era1_r <= p_era[44:SH_ERA];
      doe2_r <= doe_full[17:0];
      era2_r <= era1_r;
      t3_r   <= t3;
      doe3_r <= doe2_r;
      era3_r <= era2_r;
      yoe4_r <= p365[35:SH_365];
      doe4_r <= doe3_r;
      era4_r <= era3_r;
      doy5_r <= doy_full[DOY_W-1:0];
      yoe5_r <= yoe4_r;
      era5_r <= era4_r;
      mp6_r  <= p153[22:SH_153];
      doy6_r <= doy5_r;
      yoe6_r <= yoe5_r;
      era6_r <= era5_r;
      date_r <= date7;
    end
  end

  assign valid_o = v_r[CIV_LAT-1];
  assign date_o  = date_r;
  assign side_o  = side_r[CIV_LAT-1];

endmodule

>>> rtl/ntz_dst.sv
// Daylight decision from the UTC date, then the local day and second of day.
// Four stages. Depends on ntz_pkg.
module ntz_dst (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  ntz_pkg::civ_date_t          date_i,
  input  ntz_pkg::utc_side_t          side_i,
  output logic                        valid_o,
  output logic [ntz_pkg::DAYS_W-1:0]  z_o,
  output logic [ntz_pkg::SOD_W-1:0]   sod_o,
  output logic                        daylight_o
);
  import ntz_pkg::*;

  function automatic logic [2:0] mod7(input logic [9:0] x);
    logic [20:0] p;
    logic [9:0]  r;
    p = 21'(x) * 21'(M_7S);
    r = x - 10'(p[20:SH_7S]) * 10'd7;
    return r[2:0];
  endfunction

  logic [3:0]        v_r;
  logic [DOY_W-1:0]  doyj;
  logic [DOY_W-1:0]  doyj1_r;
  logic [9:0]        ds1_r;
  logic [9:0]        da1_r;
  logic              leap1_r;
  logic [2:0]        wday1_r;
  logic [DAYS_W-1:0] z1_r;
  logic [SOD_W-1:0]  sod1_r;
  logic [2:0]        ws2_r;
  logic [2:0]        wa2_r;
  logic [DOY_W-1:0]  doyj2_r;
  logic              leap2_r;
  logic [DAYS_W-1:0] z2_r;
  logic [SOD_W-1:0]  sod2_r;
  logic [DOY_W-1:0]  sep_eve;
  logic [DOY_W-1:0]  apr_eve;
  logic              late_sod;
  logic              dst3;
  logic              dst3_r;
  logic [DAYS_W-1:0] z3_r;
  logic [SOD_W-1:0]  sod3_r;
  logic [SOD_W:0]    sod_sum;
  logic              carry;
  logic [DAYS_W-1:0] z4_r;
  logic [SOD_W-1:0]  sod4_r;
  logic              dst4_r;

  always_comb begin
    // January-based day of year of the UTC date.
    doyj = (date_i.mp >= 4'd10) ? (date_i.doy - 9'd306)
                                : (date_i.doy + 9'd59 + 9'(date_i.leap));

    // 30 September is day 272 and 1 April day 90 in a common year.
    sep_eve  = 9'd271 + 9'(leap2_r) - 9'(ws2_r);
    apr_eve  = 9'd89 + 9'(leap2_r) + ((wa2_r == 3'd0) ? 9'd0 : (9'd7 - 9'(wa2_r)));
    late_sod = (sod2_r >= SWITCH_SOD);
    dst3     = (doyj2_r > sep_eve) || ((doyj2_r == sep_eve) && late_sod)
            || (doyj2_r < apr_eve) || ((doyj2_r == apr_eve) && !late_sod);

    sod_sum = 18'(sod3_r) + 18'(dst3_r ? DST_OFFSET : STD_OFFSET);
    carry   = (sod_sum >= 18'(SECS_PER_DAY));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      doyj1_r <= doyj;
      // Offsets of 371 keep both weekday sums positive without changing them mod 7.
      ds1_r   <= 10'd643 + 10'(date_i.leap) - 10'(doyj);
      da1_r   <= 10'd461 + 10'(date_i.leap) - 10'(doyj);
      leap1_r <= date_i.leap;
      wday1_r <= side_i.wday;
      z1_r    <= side_i.z;
      sod1_r  <= side_i.sod;

      ws2_r   <= mod7(ds1_r + 10'(wday1_r));
      wa2_r   <= mod7(da1_r + 10'(wday1_r));
      doyj2_r <= doyj1_r;
      leap2_r <= leap1_r;
      z2_r    <= z1_r;
      sod2_r  <= sod1_r;

      dst3_r <= dst3;
      z3_r   <= z2_r;
      sod3_r <= sod2_r;

      dst4_r <= dst3_r;
      z4_r   <= z3_r + 22'(carry);
      sod4_r <= carry ? SOD_W'(sod_sum - 18'(SECS_PER_DAY)) : sod_sum[SOD_W-1:0];
    end
  end

  assign valid_o    = v_r[3];
  assign z_o        = z4_r;
  assign sod_o      = sod4_r;
  assign daylight_o = dst4_r;

endmodule

>>> rtl/ntz_hms.sv
// Splits the local second of day into hour, minute and second (4 stages).
// The last stage is the block's output register. Depends on ntz_pkg.
module ntz_hms (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         valid_i,
  input  ntz_pkg::civ_date_t           date_i,
  input  logic [ntz_pkg::SOD_W-1:0]    sod_i,
  input  logic                         daylight_i,
  output logic                         valid_o,
  output logic [ntz_pkg::YEAR_W-1:0]   year_o,
  output logic [ntz_pkg::MONTH_W-1:0]  month_o,
  output logic [ntz_pkg::DAY_W-1:0]    day_o,
  output logic [ntz_pkg::HOUR_W-1:0]   hour_o,
  output logic [ntz_pkg::MIN_W-1:0]    minute_o,
  output logic [ntz_pkg::SEC_W-1:0]    second_o,
  output logic                         daylight_o
);
  import ntz_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               daylight;
  } ymd_t;

  logic [3:0]        v_r;
  ymd_t              ymd_in;
  ymd_t              ymd_r [4];
  logic [34:0]       p3600;
  logic [HOUR_W-1:0] hour1_r;
  logic [SOD_W-1:0]  sod1_r;
  logic [SOD_W-1:0]  rem_full;
  logic [HOUR_W-1:0] hour2_r;
  logic [11:0]       rem2_r;
  logic [24:0]       p60;
  logic [HOUR_W-1:0] hour3_r;
  logic [MIN_W-1:0]  min3_r;
  logic [11:0]       rem3_r;
  logic [11:0]       sec_full;
  logic [HOUR_W-1:0] hour4_r;
  logic [MIN_W-1:0]  min4_r;
  logic [SEC_W-1:0]  sec4_r;

  assign ymd_in   = '{year: date_i.year, month: date_i.month, day: date_i.day,
                      daylight: daylight_i};
  assign p3600    = 35'(sod_i) * 35'(M_3600);
  assign rem_full = sod1_r - 17'(hour1_r) * 17'd3600;
  assign p60      = 25'(rem2_r) * 25'(M_60);
  assign sec_full = rem3_r - 12'(min3_r) * 12'd60;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ymd_r[0] <= ymd_in;
      for (int k = 1; k < 4; k++) begin
        ymd_r[k] <= ymd_r[k-1];
      end
      hour1_r <= p3600[33:SH_3600];
      sod1_r  <= sod_i;
      hour2_r <= hour1_r;
      rem2_r  <= rem_full[11:0];
      hour3_r <= hour2_r;
      min3_r  <= p60[23:SH_60];
      rem3_r  <= rem2_r;
      hour4_r <= hour3_r;
      min4_r  <= min3_r;
      sec4_r  <= sec_full[SEC_W-1:0];
    end
  end

  assign valid_o    = v_r[3];
  assign year_o     = ymd_r[3].year;
  assign month_o    = ymd_r[3].month;
  assign day_o      = ymd_r[3].day;
  assign daylight_o = ymd_r[3].daylight;
  assign hour_o     = hour4_r;
  assign minute_o   = min4_r;
  assign second_o   = sec4_r;

endmodule

>>> rtl/epoch_to_nz_local_time_top.sv
// Top level of the epoch to New Zealand local time converter.
// Depends on ntz_pkg, ntz_split, ntz_civil, ntz_dst and ntz_hms.

// Takes one epoch beat per clock while the chain is not held and returns its
// New Zealand local date and time after these steps in order: splitting off the
// UTC day, second and weekday; the UTC calendar date; the daylight decision and
// local day; the local calendar date; hours, minutes and seconds. The pipeline
// is a single chain of registers with valid bits; when a finished result is
// not taken, the whole chain holds, so in_ready is low only while a result waits
// on out_ready, and one beat a cycle flows whenever the sink keeps up.
module epoch_to_nz_local_time_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ntz_pkg::EPOCH_W-1:0]  in_epoch_seconds,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ntz_pkg::YEAR_W-1:0]   out_year,
  output logic [ntz_pkg::MONTH_W-1:0]  out_month,
  output logic [ntz_pkg::DAY_W-1:0]    out_day,
  output logic [ntz_pkg::HOUR_W-1:0]   out_hour,
  output logic [ntz_pkg::MIN_W-1:0]    out_minute,
  output logic [ntz_pkg::SEC_W-1:0]    out_second,
  output logic                         out_daylight
);
  import ntz_pkg::*;

  logic              en;
  logic              split_valid;
  utc_side_t         split_side;
  logic              utc_valid;
  civ_date_t         utc_date;
  civ_side_t         utc_side;
  logic              dst_valid;
  logic [DAYS_W-1:0] loc_z;
  logic [SOD_W-1:0]  loc_sod;
  logic              loc_dst;
  logic              loc_valid;
  civ_date_t         loc_date;
  civ_side_t         loc_side;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ntz_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .epoch_i (in_epoch_seconds),
    .valid_o (split_valid),
    .side_o  (split_side)
  );

  ntz_civil u_utc_civil (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (split_valid),
    .z_i     (split_side.z),
    .side_i  (civ_side_t'(split_side)),
    .valid_o (utc_valid),
    .date_o  (utc_date),
    .side_o  (utc_side)
  );

  ntz_dst u_dst (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .valid_i    (utc_valid),
    .date_i     (utc_date),
    .side_i     (utc_side_t'(utc_side)),
    .valid_o    (dst_valid),
    .z_o        (loc_z),
    .sod_o      (loc_sod),
    .daylight_o (loc_dst)
  );

  // The local pass carries the second of day and daylight flag in the low bits.
  ntz_civil u_loc_civil (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (dst_valid),
    .z_i     (loc_z),
    .side_i  (CIV_SIDE_W'({loc_sod, loc_dst})),
    .valid_o (loc_valid),
    .date_o  (loc_date),
    .side_o  (loc_side)
  );

  ntz_hms u_hms (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .valid_i    (loc_valid),
    .date_i     (loc_date),
    .sod_i      (loc_side[SOD_W:1]),
    .daylight_i (loc_side[0]),
    .valid_o    (out_valid),
    .year_o     (out_year),
    .month_o    (out_month),
    .day_o      (out_day),
    .hour_o     (out_hour),
    .minute_o   (out_minute),
    .second_o   (out_second),
    .daylight_o (out_daylight)
  );

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12))
    else $error("local month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_day >= 5'd1) && (out_day <= 5'd31))
    else $error("local day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59))
    else $error("local time of day out of range");

  a_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> !in_ready || out_ready)
    else $error("pipeline advanced while the output was stalled");

endmodule
